// ===== rtl/core/obb_pkg.sv =====
// ----------------------------------------------------------------------------
// obb_pkg
// Shared constants for the oriented-box separating-axis overlap test.
// ----------------------------------------------------------------------------
package obb_pkg;

  localparam int COORD_WIDTH_DEF      = 32;
  localparam int ANGLE_BITS_DEF       = 16;
  localparam int SINE_TABLE_DEPTH_DEF = 1024;

  localparam int TRIG_W      = 16;
  localparam int AXIS_W      = TRIG_W + 1;
  localparam int FRAC_BITS   = 15;
  localparam int NUM_CORNERS = 4;
  localparam int NUM_AXES    = 4;
  localparam int PIPE_STAGES = 7;

  localparam logic [63:0] TWO_PI_Q30 = 64'd6746518852;
  localparam int          SERIES_TERMS = 7;
  localparam logic [7:0]  SERIES_DIV [SERIES_TERMS] = '{8'd6, 8'd20, 8'd42, 8'd72,
                                                        8'd110, 8'd156, 8'd210};

endpackage

// ===== rtl/core/obb_box_lane.sv =====
// ----------------------------------------------------------------------------
// obb_box_lane
// Per-box lane: sine/cosine lookup, extent rotation, four corner points.
// ----------------------------------------------------------------------------
module obb_box_lane import obb_pkg::*; #(
  parameter int COORD_WIDTH      = COORD_WIDTH_DEF,
  parameter int ANGLE_BITS       = ANGLE_BITS_DEF,
  parameter int SINE_TABLE_DEPTH = SINE_TABLE_DEPTH_DEF,
  parameter int CORNER_W         = COORD_WIDTH + 4
) (
  input  logic                        clk,
  input  logic                        en,
  input  logic signed [COORD_WIDTH-1:0] center_x,
  input  logic signed [COORD_WIDTH-1:0] center_y,
  input  logic [COORD_WIDTH-2:0]      ext_len,
  input  logic [COORD_WIDTH-2:0]      ext_wid,
  input  logic [ANGLE_BITS-1:0]       heading,
  output logic signed [CORNER_W-1:0]  corner_x [NUM_CORNERS],
  output logic signed [CORNER_W-1:0]  corner_y [NUM_CORNERS],
  output logic signed [TRIG_W-1:0]    cos_o,
  output logic signed [TRIG_W-1:0]    sin_o
);

  localparam int IDX_W  = $clog2(SINE_TABLE_DEPTH);
  localparam int PRW    = ANGLE_BITS + IDX_W + 1;
  localparam int PW     = COORD_WIDTH + TRIG_W;
  localparam int TW     = COORD_WIDTH + 2;
  localparam logic [ANGLE_BITS-1:0] QUARTER = ANGLE_BITS'(1) << (ANGLE_BITS - 2);

  typedef logic signed [TRIG_W-1:0] tab_t [SINE_TABLE_DEPTH];

  function automatic tab_t build_tab();
    tab_t               t;
    int                 k;
    int                 n;
    logic [63:0]        u;
    logic [63:0]        x;
    logic [63:0]        x2;
    logic [63:0]        term;
    logic signed [63:0] sum;
    logic signed [63:0] q;
    logic               neg;
    for (k = 0; k < SINE_TABLE_DEPTH; k++) begin
      u   = (64'(k) << 32) / 64'(SINE_TABLE_DEPTH);
      neg = 1'b0;
      if (u >= (64'd1 << 31)) begin
        neg = 1'b1;
        u   = u - (64'd1 << 31);
      end
      if (u > (64'd1 << 30)) begin
        u = (64'd1 << 31) - u;
      end
      x    = (u * TWO_PI_Q30) >> 32;
      x2   = (x * x) >> 30;
      term = x;
      sum  = signed'(x);
      for (n = 1; n <= SERIES_TERMS; n++) begin
        term = ((term * x2) >> 30) / 64'(SERIES_DIV[n-1]);
        if (n % 2 == 1) begin
          sum = sum - signed'(term);
        end else begin
          sum = sum + signed'(term);
        end
      end
      if (sum < 0) begin
        sum = 0;
      end
      q = (sum + 64'sd16384) >>> 15;
      if (q > 64'sd32767) begin
        q = 64'sd32767;
      end
      t[k] = neg ? TRIG_W'(-q) : TRIG_W'(q);
    end
    return t;
  endfunction

  localparam tab_t SIN_TAB = build_tab();

  function automatic logic signed [TW-1:0] fl_pos(input logic signed [PW-1:0] p);
    return TW'(p >>> FRAC_BITS);
  endfunction

  function automatic logic signed [TW-1:0] fl_neg(input logic signed [PW-1:0] p);
    logic signed [PW-1:0] m;
    m = -p;
    return TW'(m >>> FRAC_BITS);
  endfunction

  // stage 1: trig lookup
  logic [PRW-1:0]                 prod_s;
  logic [PRW-1:0]                 prod_c;
  logic [ANGLE_BITS-1:0]          heading_c;
  logic signed [TRIG_W-1:0]       sin1_r, cos1_r;
  logic signed [COORD_WIDTH-1:0]  cx1_r, cy1_r;
  logic [COORD_WIDTH-2:0]         l1_r, w1_r;

  assign heading_c = heading + QUARTER;
  assign prod_s    = PRW'(heading)   * PRW'(SINE_TABLE_DEPTH);
  assign prod_c    = PRW'(heading_c) * PRW'(SINE_TABLE_DEPTH);

  always_ff @(posedge clk) begin
    if (en) begin
      sin1_r <= SIN_TAB[prod_s[ANGLE_BITS +: IDX_W]];
      cos1_r <= SIN_TAB[prod_c[ANGLE_BITS +: IDX_W]];
      cx1_r  <= center_x;
      cy1_r  <= center_y;
      l1_r   <= ext_len;
      w1_r   <= ext_wid;
    end
  end

  // stage 2: extent products
  logic signed [COORD_WIDTH-1:0] l_s, w_s;
  logic signed [PW-1:0]          p_lc_r, p_ls_r, p_wc_r, p_ws_r;
  logic signed [COORD_WIDTH-1:0] cx2_r, cy2_r;
  logic signed [TRIG_W-1:0]      sin2_r, cos2_r;

  assign l_s = signed'({1'b0, l1_r});
  assign w_s = signed'({1'b0, w1_r});

  always_ff @(posedge clk) begin
    if (en) begin
      p_lc_r <= PW'(l_s) * PW'(cos1_r);
      p_ls_r <= PW'(l_s) * PW'(sin1_r);
      p_wc_r <= PW'(w_s) * PW'(cos1_r);
      p_ws_r <= PW'(w_s) * PW'(sin1_r);
      cx2_r  <= cx1_r;
      cy2_r  <= cy1_r;
      sin2_r <= sin1_r;
      cos2_r <= cos1_r;
    end
  end

  // stage 3: corners
  logic signed [CORNER_W-1:0] cx_e, cy_e;
  logic signed [CORNER_W-1:0] lc_p, lc_n, ls_p, ls_n, wc_p, wc_n, ws_p, ws_n;
  logic signed [CORNER_W-1:0] x_nxt [NUM_CORNERS];
  logic signed [CORNER_W-1:0] y_nxt [NUM_CORNERS];

  assign cx_e = CORNER_W'(cx2_r);
  assign cy_e = CORNER_W'(cy2_r);
  assign lc_p = CORNER_W'(fl_pos(p_lc_r));
  assign lc_n = CORNER_W'(fl_neg(p_lc_r));
  assign ls_p = CORNER_W'(fl_pos(p_ls_r));
  assign ls_n = CORNER_W'(fl_neg(p_ls_r));
  assign wc_p = CORNER_W'(fl_pos(p_wc_r));
  assign wc_n = CORNER_W'(fl_neg(p_wc_r));
  assign ws_p = CORNER_W'(fl_pos(p_ws_r));
  assign ws_n = CORNER_W'(fl_neg(p_ws_r));

  assign x_nxt[0] = cx_e + lc_p - ws_p;
  assign x_nxt[1] = cx_e + lc_p - ws_n;
  assign x_nxt[2] = cx_e + lc_n - ws_n;
  assign x_nxt[3] = cx_e + lc_n - ws_p;
  assign y_nxt[0] = cy_e + ls_p + wc_p;
  assign y_nxt[1] = cy_e + ls_p + wc_n;
  assign y_nxt[2] = cy_e + ls_n + wc_n;
  assign y_nxt[3] = cy_e + ls_n + wc_p;

  always_ff @(posedge clk) begin
    if (en) begin
      corner_x <= x_nxt;
      corner_y <= y_nxt;
      sin_o    <= sin2_r;
      cos_o    <= cos2_r;
    end
  end

endmodule

// ===== rtl/core/obb_axis_lane.sv =====
// ----------------------------------------------------------------------------
// obb_axis_lane
// Per-axis lane: projects both corner sets, forms intervals, flags a gap.
// ----------------------------------------------------------------------------
module obb_axis_lane import obb_pkg::*; #(
  parameter int COORD_WIDTH = COORD_WIDTH_DEF,
  parameter int CORNER_W    = COORD_WIDTH + 4
) (
  input  logic                       clk,
  input  logic                       en,
  input  logic signed [AXIS_W-1:0]   ax,
  input  logic signed [AXIS_W-1:0]   ay,
  input  logic signed [CORNER_W-1:0] a_x [NUM_CORNERS],
  input  logic signed [CORNER_W-1:0] a_y [NUM_CORNERS],
  input  logic signed [CORNER_W-1:0] b_x [NUM_CORNERS],
  input  logic signed [CORNER_W-1:0] b_y [NUM_CORNERS],
  output logic                       separated
);

  localparam int NP = 2 * NUM_CORNERS;
  localparam int PW = CORNER_W + AXIS_W;
  localparam int JW = PW - FRAC_BITS + 1;

  logic signed [CORNER_W-1:0] pt_x [NP];
  logic signed [CORNER_W-1:0] pt_y [NP];
  logic signed [PW-1:0]       px_r [NP];
  logic signed [PW-1:0]       py_r [NP];
  logic signed [JW-1:0]       proj_r [NP];
  logic signed [JW-1:0]       amn_r, amx_r, bmn_r, bmx_r;
  logic signed [JW-1:0]       amn, amx, bmn, bmx;

  always_comb begin
    for (int i = 0; i < NUM_CORNERS; i++) begin
      pt_x[i]               = a_x[i];
      pt_y[i]               = a_y[i];
      pt_x[i + NUM_CORNERS] = b_x[i];
      pt_y[i + NUM_CORNERS] = b_y[i];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < NP; i++) begin
        px_r[i]   <= PW'(pt_x[i]) * PW'(ax);
        py_r[i]   <= PW'(pt_y[i]) * PW'(ay);
        proj_r[i] <= JW'(px_r[i] >>> FRAC_BITS) + JW'(py_r[i] >>> FRAC_BITS);
      end
    end
  end

  always_comb begin
    amn = proj_r[0];
    amx = proj_r[0];
    bmn = proj_r[NUM_CORNERS];
    bmx = proj_r[NUM_CORNERS];
    for (int i = 1; i < NUM_CORNERS; i++) begin
      if (proj_r[i] < amn) amn = proj_r[i];
      if (proj_r[i] > amx) amx = proj_r[i];
      if (proj_r[i + NUM_CORNERS] < bmn) bmn = proj_r[i + NUM_CORNERS];
      if (proj_r[i + NUM_CORNERS] > bmx) bmx = proj_r[i + NUM_CORNERS];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      amn_r     <= amn;
      amx_r     <= amx;
      bmn_r     <= bmn;
      bmx_r     <= bmx;
      separated <= (amx_r < bmn_r) || (bmx_r < amn_r);
    end
  end

endmodule

// ===== rtl/core/obb_overlap_sat.sv =====
// ----------------------------------------------------------------------------
// obb_overlap_sat
// Separating-axis overlap test for two oriented 2D boxes.
// Throughput one request per cycle while the skid entry is empty (in_ready high).
// Rate is set by the fully pipelined lanes (two box lanes, four axis lanes)
// and a two-entry output register with skid.
// Reset clears the valid pipeline and the output/skid valid flags only.
// ----------------------------------------------------------------------------
module obb_overlap_sat import obb_pkg::*; #(
  parameter int COORD_WIDTH      = COORD_WIDTH_DEF,
  parameter int ANGLE_BITS       = ANGLE_BITS_DEF,
  parameter int SINE_TABLE_DEPTH = SINE_TABLE_DEPTH_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic signed [COORD_WIDTH-1:0] in_a_center_x,
  input  logic signed [COORD_WIDTH-1:0] in_a_center_y,
  input  logic [COORD_WIDTH-2:0]        in_a_half_length,
  input  logic [COORD_WIDTH-2:0]        in_a_half_width,
  input  logic [ANGLE_BITS-1:0]         in_a_heading,
  input  logic signed [COORD_WIDTH-1:0] in_b_center_x,
  input  logic signed [COORD_WIDTH-1:0] in_b_center_y,
  input  logic [COORD_WIDTH-2:0]        in_b_half_length,
  input  logic [COORD_WIDTH-2:0]        in_b_half_width,
  input  logic [ANGLE_BITS-1:0]         in_b_heading,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic                          out_overlap
);

  localparam int CORNER_W = COORD_WIDTH + 4;

  logic                       en;
  logic [PIPE_STAGES-1:0]     vld_r, vld_nxt;
  logic signed [CORNER_W-1:0] a_x [NUM_CORNERS];
  logic signed [CORNER_W-1:0] a_y [NUM_CORNERS];
  logic signed [CORNER_W-1:0] b_x [NUM_CORNERS];
  logic signed [CORNER_W-1:0] b_y [NUM_CORNERS];
  logic signed [TRIG_W-1:0]   a_cos, a_sin, b_cos, b_sin;
  logic signed [AXIS_W-1:0]   ax [NUM_AXES];
  logic signed [AXIS_W-1:0]   ay [NUM_AXES];
  logic [NUM_AXES-1:0]        sep;
  logic out_valid_r, out_overlap_r, skid_valid_r, skid_overlap_r;
  logic done, hit;

  assign en       = !skid_valid_r;
  assign in_ready = en;

  obb_box_lane #(
    .COORD_WIDTH(COORD_WIDTH), .ANGLE_BITS(ANGLE_BITS),
    .SINE_TABLE_DEPTH(SINE_TABLE_DEPTH), .CORNER_W(CORNER_W)
  ) u_box_a (
    .clk(clk), .en(en),
    .center_x(in_a_center_x), .center_y(in_a_center_y),
    .ext_len(in_a_half_length), .ext_wid(in_a_half_width),
    .heading(in_a_heading),
    .corner_x(a_x), .corner_y(a_y), .cos_o(a_cos), .sin_o(a_sin)
  );

  obb_box_lane #(
    .COORD_WIDTH(COORD_WIDTH), .ANGLE_BITS(ANGLE_BITS),
    .SINE_TABLE_DEPTH(SINE_TABLE_DEPTH), .CORNER_W(CORNER_W)
  ) u_box_b (
    .clk(clk), .en(en),
    .center_x(in_b_center_x), .center_y(in_b_center_y),
    .ext_len(in_b_half_length), .ext_wid(in_b_half_width),
    .heading(in_b_heading),
    .corner_x(b_x), .corner_y(b_y), .cos_o(b_cos), .sin_o(b_sin)
  );

  // box axes: (c, s) and (-s, c)
  assign ax[0] = AXIS_W'(a_cos);
  assign ay[0] = AXIS_W'(a_sin);
  assign ax[1] = -AXIS_W'(a_sin);
  assign ay[1] = AXIS_W'(a_cos);
  assign ax[2] = AXIS_W'(b_cos);
  assign ay[2] = AXIS_W'(b_sin);
  assign ax[3] = -AXIS_W'(b_sin);
  assign ay[3] = AXIS_W'(b_cos);

  for (genvar g = 0; g < NUM_AXES; g++) begin : g_axis
    obb_axis_lane #(
      .COORD_WIDTH(COORD_WIDTH), .CORNER_W(CORNER_W)
    ) u_axis (
      .clk(clk), .en(en), .ax(ax[g]), .ay(ay[g]),
      .a_x(a_x), .a_y(a_y), .b_x(b_x), .b_y(b_y),
      .separated(sep[g])
    );
  end

  // valid pipeline
  assign vld_nxt = {vld_r[PIPE_STAGES-2:0], in_valid};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (en) begin
      vld_r <= vld_nxt;
    end
  end

  // merge and output register with skid
  assign done = en && vld_r[PIPE_STAGES-1];
  assign hit  = ~|sep;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else if (!out_valid_r || out_ready) begin
      if (skid_valid_r) begin
        out_valid_r  <= 1'b1;
        skid_valid_r <= 1'b0;
      end else begin
        out_valid_r <= done;
      end
    end else if (done) begin
      skid_valid_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!out_valid_r || out_ready) begin
      out_overlap_r <= skid_valid_r ? skid_overlap_r : hit;
    end else if (done) begin
      skid_overlap_r <= hit;
    end
  end

  assign out_valid   = out_valid_r;
  assign out_overlap = out_overlap_r;

endmodule
